[hw/rtl/tse_pkg.sv]
`default_nettype none

package tse_pkg;

  // Series length
  localparam int MAX_TERMS  = 8;
  localparam int TERM_CNT_W = 4;

  // Field widths
  localparam int ANG_W = 32;          // Q3.28 angle, Q28 magnitude
  localparam int OUT_W = 32;          // Q7.24 result

  // Datapath widths
  localparam int SQ_W       = 2 * ANG_W;          // a*a
  localparam int X2_W       = 31;                 // x^2 in Q24, up to 2^30
  localparam int R_W        = 30;                 // reciprocal divisors, Q32
  localparam int PF_W       = X2_W + R_W;         // x2 * R
  localparam int F_W        = 28;                 // term factor, Q24
  localparam int T_W        = 40;                 // term magnitude, Q30
  localparam int T_SPLIT    = 20;                 // low slice of a term
  localparam int PP_W       = T_SPLIT + F_W;      // one partial product
  localparam int PROD_W     = T_W + F_W;          // full term product
  localparam int SUM_W      = 44;                 // signed Q30 series sum
  localparam int RND_W      = SUM_W + 1;          // magnitude plus rounding
  localparam int SHIFT_X2   = 32;
  localparam int SHIFT_F    = 32;
  localparam int SHIFT_T    = 24;
  localparam int SHIFT_OUT  = 6;

  // round(2^32 / ((2k)(2k+1))) for k = 1 .. MAX_TERMS
  localparam logic [R_W-1:0] RECIP [MAX_TERMS] = '{
    30'd715827883, 30'd214748365, 30'd102261126, 30'd59652324,
    30'd39045157,  30'd27531842,  30'd20452225,  30'd15790321
  };

  // Load enables for the two registers of one term section
  typedef struct packed {
    logic p;
    logic c;
  } tse_en_t;

endpackage

`default_nettype wire

[hw/rtl/tse_term.sv]
`default_nettype none

// One series term: partial products of the running term by its factor, then
// recombine, round and fold into the sum. The next factor is formed alongside.
module tse_term (
  input  wire logic                         clk,
  input  wire tse_pkg::tse_en_t             en,
  input  wire logic [tse_pkg::R_W-1:0]      recip_next,
  input  wire logic                         use_term,
  input  wire logic                         subtract,
  input  wire logic [tse_pkg::X2_W-1:0]     x2_in,
  input  wire logic [tse_pkg::T_W-1:0]      term_in,
  input  wire logic [tse_pkg::F_W-1:0]      f_in,
  input  wire logic signed [tse_pkg::SUM_W-1:0] sum_in,
  input  wire logic                         neg_in,
  input  wire logic                         last_in,
  output logic [tse_pkg::X2_W-1:0]          x2_out,
  output logic [tse_pkg::T_W-1:0]           term_out,
  output logic [tse_pkg::F_W-1:0]           f_out,
  output logic signed [tse_pkg::SUM_W-1:0]  sum_out,
  output logic                              neg_out,
  output logic                              last_out
);
  import tse_pkg::*;

  localparam logic [PROD_W-1:0] T_HALF  = PROD_W'(1) << (SHIFT_T - 1);
  localparam logic [PF_W:0]     F_HALF  = (PF_W + 1)'(1) << (SHIFT_F - 1);

  // Partial product stage
  logic [PP_W-1:0]         pl_r, ph_r;
  logic [PF_W-1:0]         pf_r;
  logic [X2_W-1:0]         x2p_r;
  logic signed [SUM_W-1:0] sump_r;
  logic                    negp_r, lastp_r;

  // Recombine stage
  logic [PROD_W-1:0]       prod_full;
  logic [PF_W:0]           pf_round;
  logic [T_W-1:0]          term_nxt;
  logic signed [SUM_W-1:0] term_ext;
  logic signed [SUM_W-1:0] sum_nxt;
  logic [T_W-1:0]          term_r;
  logic [F_W-1:0]          f_r;
  logic [X2_W-1:0]         x2_r;
  logic signed [SUM_W-1:0] sum_r;
  logic                    neg_r, last_r;

  // Multiply both slices of the term and form the next factor product
  always_ff @(posedge clk) begin
    if (en.p) begin
      pl_r    <= PP_W'(term_in[T_SPLIT-1:0]) * PP_W'(f_in);
      ph_r    <= PP_W'(term_in[T_W-1:T_SPLIT]) * PP_W'(f_in);
      pf_r    <= PF_W'(x2_in) * PF_W'(recip_next);
      x2p_r   <= x2_in;
      sump_r  <= sum_in;
      negp_r  <= neg_in;
      lastp_r <= last_in;
    end
  end

  // Recombine the slices, round the term and the next factor, accumulate
  always_comb begin
    prod_full = {ph_r, {T_SPLIT{1'b0}}} + {{(PROD_W-PP_W){1'b0}}, pl_r} + T_HALF;
    term_nxt  = prod_full[SHIFT_T +: T_W];
    pf_round  = {1'b0, pf_r} + F_HALF;
    term_ext  = $signed({{(SUM_W-T_W){1'b0}}, term_nxt});
    sum_nxt   = sump_r;
    if (use_term) begin
      if (subtract) begin
        sum_nxt = sump_r - term_ext;
      end else begin
        sum_nxt = sump_r + term_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.c) begin
      term_r <= term_nxt;
      f_r    <= pf_round[SHIFT_F +: F_W];
      x2_r   <= x2p_r;
      sum_r  <= sum_nxt;
      neg_r  <= negp_r;
      last_r <= lastp_r;
    end
  end

  assign x2_out   = x2_r;
  assign term_out = term_r;
  assign f_out    = f_r;
  assign sum_out  = sum_r;
  assign neg_out  = neg_r;
  assign last_out = last_r;

endmodule

`default_nettype wire

[hw/rtl/taylor_sine_evaluator_core.sv]
`default_nettype none

// Taylor-series sine evaluator.
// in_*  : one angle word per handshake, in_tdata = angle (signed Q3.28),
//         in_tlast = last angle of a batch.
// out_* : one result word per angle, in the same order, out_tdata = sine
//         (signed Q7.24, saturated), out_tlast = copy of in_tlast.
// cfg_* : write of num_terms (terms after the linear one, above 8 taken
//         as 8); cfg_ready is always high. Write only while the pipe is empty.
// Pipeline: 24 register stages (5 front, two per series term for 8 terms,
// 3 at the output), whatever num_terms holds.
// Throughput: one word per cycle while out_tready is high; each stage holds
// one word with a valid bit, loading whenever empty or the stage after moves.
// Stall: when out_tready is low the words close up behind the output
// register; in_tready drops only once every stage is full. Nothing is lost.
// Reset (rst_n low, synchronous) empties the pipe and sets num_terms to 5.
module taylor_sine_evaluator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] angle
  input  wire logic        in_tlast,   // final_angle
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] sine_value
  output logic             out_tlast,  // final_result
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data    // [3:0] num_terms
);
  import tse_pkg::*;

  localparam int ST_IN  = 0;
  localparam int ST_SQ  = 1;
  localparam int ST_X2  = 2;
  localparam int ST_PF  = 3;
  localparam int ST_F   = 4;
  localparam int ST_MAG = ST_F + 1 + 2 * MAX_TERMS;
  localparam int ST_RND = ST_MAG + 1;
  localparam int ST_OUT = ST_RND + 1;
  localparam int NSTG   = ST_OUT + 1;

  localparam logic [SQ_W-1:0] X2_HALF = SQ_W'(1) << (SHIFT_X2 - 1);
  localparam logic [PF_W:0]   F_HALF  = (PF_W + 1)'(1) << (SHIFT_F - 1);
  localparam logic [RND_W-1:0] OUT_HALF = RND_W'(1) << (SHIFT_OUT - 1);
  localparam int R_OUT_W = RND_W - SHIFT_OUT;

  // Configuration
  logic [TERM_CNT_W-1:0] num_terms_r;
  logic [TERM_CNT_W-1:0] n_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_terms_r <= TERM_CNT_W'(5);
    end else if (cfg_valid) begin
      num_terms_r <= cfg_data[TERM_CNT_W-1:0];
    end
  end

  assign cfg_ready = 1'b1;
  assign n_sat = (num_terms_r > TERM_CNT_W'(MAX_TERMS)) ? TERM_CNT_W'(MAX_TERMS)
                                                         : num_terms_r;

  // Valid bits and load enables: a stage loads when empty or when it moves on
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  always_comb begin
    adv[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= (i == 0) ? in_tvalid : vld_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_tready = adv[0];

  // Stage 0: take the magnitude of the angle
  logic [ANG_W-1:0] a0_r;
  logic             neg0_r, last0_r;

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      a0_r    <= in_tdata[ANG_W-1] ? (ANG_W'(0) - in_tdata[ANG_W-1:0])
                                   : in_tdata[ANG_W-1:0];
      neg0_r  <= in_tdata[ANG_W-1];
      last0_r <= in_tlast;
    end
  end

  // Stage 1: square the magnitude, set the linear term
  logic [SQ_W-1:0] sq1_r;
  logic [T_W-1:0]  t1_r;
  logic            neg1_r, last1_r;

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      sq1_r   <= SQ_W'(a0_r) * SQ_W'(a0_r);
      t1_r    <= T_W'({a0_r, 2'b00});
      neg1_r  <= neg0_r;
      last1_r <= last0_r;
    end
  end

  // Stage 2: round x^2 to Q24
  logic [SQ_W-1:0]  sq_round;
  logic [X2_W-1:0]  x2_2_r;
  logic [T_W-1:0]   t2_r;
  logic             neg2_r, last2_r;

  assign sq_round = sq1_r + X2_HALF;

  always_ff @(posedge clk) begin
    if (adv[ST_X2]) begin
      x2_2_r  <= sq_round[SHIFT_X2 +: X2_W];
      t2_r    <= t1_r;
      neg2_r  <= neg1_r;
      last2_r <= last1_r;
    end
  end

  // Stage 3: first factor product
  logic [PF_W-1:0] pf3_r;
  logic [X2_W-1:0] x2_3_r;
  logic [T_W-1:0]  t3_r;
  logic            neg3_r, last3_r;

  always_ff @(posedge clk) begin
    if (adv[ST_PF]) begin
      pf3_r   <= PF_W'(x2_2_r) * PF_W'(RECIP[0]);
      x2_3_r  <= x2_2_r;
      t3_r    <= t2_r;
      neg3_r  <= neg2_r;
      last3_r <= last2_r;
    end
  end

  // Stage 4: round the first factor, open the sum with the linear term
  logic [PF_W:0] pf_round;

  assign pf_round = {1'b0, pf3_r} + F_HALF;

  logic [X2_W-1:0]         x2_c   [MAX_TERMS+1];
  logic [T_W-1:0]          t_c    [MAX_TERMS+1];
  logic [F_W-1:0]          f_c    [MAX_TERMS+1];
  logic signed [SUM_W-1:0] sum_c  [MAX_TERMS+1];
  logic                    neg_c  [MAX_TERMS+1];
  logic                    last_c [MAX_TERMS+1];

  logic [X2_W-1:0]         x2_4_r;
  logic [T_W-1:0]          t4_r;
  logic [F_W-1:0]          f4_r;
  logic signed [SUM_W-1:0] sum4_r;
  logic                    neg4_r, last4_r;

  always_ff @(posedge clk) begin
    if (adv[ST_F]) begin
      x2_4_r  <= x2_3_r;
      t4_r    <= t3_r;
      f4_r    <= pf_round[SHIFT_F +: F_W];
      sum4_r  <= $signed({{(SUM_W-T_W){1'b0}}, t3_r});
      neg4_r  <= neg3_r;
      last4_r <= last3_r;
    end
  end

  assign x2_c[0]   = x2_4_r;
  assign t_c[0]    = t4_r;
  assign f_c[0]    = f4_r;
  assign sum_c[0]  = sum4_r;
  assign neg_c[0]  = neg4_r;
  assign last_c[0] = last4_r;

  // Term sections, two stages each
  for (genvar g = 0; g < MAX_TERMS; g++) begin : g_term
    tse_en_t en;
    logic    use_term;

    assign en.p     = adv[ST_F + 1 + 2 * g];
    assign en.c     = adv[ST_F + 2 + 2 * g];
    assign use_term = (TERM_CNT_W'(g + 1) <= n_sat);

    tse_term u_term (
      .clk        (clk),
      .en         (en),
      .recip_next ((g + 1 < MAX_TERMS) ? RECIP[(g + 1) % MAX_TERMS] : R_W'(0)),
      .use_term   (use_term),
      .subtract   (((g + 1) % 2) == 1),
      .x2_in      (x2_c[g]),
      .term_in    (t_c[g]),
      .f_in       (f_c[g]),
      .sum_in     (sum_c[g]),
      .neg_in     (neg_c[g]),
      .last_in    (last_c[g]),
      .x2_out     (x2_c[g+1]),
      .term_out   (t_c[g+1]),
      .f_out      (f_c[g+1]),
      .sum_out    (sum_c[g+1]),
      .neg_out    (neg_c[g+1]),
      .last_out   (last_c[g+1])
    );
  end

  // Magnitude of the sum and the final sign
  logic [SUM_W-1:0] mag_r;
  logic             negm_r, lastm_r;

  always_ff @(posedge clk) begin
    if (adv[ST_MAG]) begin
      mag_r   <= sum_c[MAX_TERMS][SUM_W-1] ? (SUM_W'(0) - sum_c[MAX_TERMS])
                                           : sum_c[MAX_TERMS];
      negm_r  <= sum_c[MAX_TERMS][SUM_W-1] ^ neg_c[MAX_TERMS];
      lastm_r <= last_c[MAX_TERMS];
    end
  end

  // Round to Q24
  logic [RND_W-1:0]   mag_round;
  logic [R_OUT_W-1:0] r_r;
  logic               negr_r, lastr_r;

  assign mag_round = {1'b0, mag_r} + OUT_HALF;

  always_ff @(posedge clk) begin
    if (adv[ST_RND]) begin
      r_r     <= mag_round[RND_W-1:SHIFT_OUT];
      negr_r  <= negm_r;
      lastr_r <= lastm_r;
    end
  end

  // Saturate, apply the sign, hold for the receiver
  logic             r_big;
  logic [OUT_W-1:0] sine_nxt;
  logic [OUT_W-1:0] sine_r;
  logic             last_out_r;

  always_comb begin
    r_big = |r_r[R_OUT_W-1:OUT_W-1];
    if (negr_r) begin
      sine_nxt = r_big ? {1'b1, {(OUT_W-1){1'b0}}} : (OUT_W'(0) - r_r[OUT_W-1:0]);
    end else begin
      sine_nxt = r_big ? {1'b0, {(OUT_W-1){1'b1}}} : r_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      sine_r     <= sine_nxt;
      last_out_r <= lastr_r;
    end
  end

  assign out_tvalid = vld_r[ST_OUT];
  assign out_tdata  = sine_r;
  assign out_tlast  = last_out_r;

endmodule

`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tse_pkg::*;

  localparam int          HALF_PERIOD  = 6;
  localparam int          RESET_CYCLES = 11;
  localparam int          PIPE_LAT     = 30;      // 24-stage pipe plus margin
  localparam int          MAX_GAP      = 18;
  localparam int          CHOKE_CYCLES = 300;
  localparam int          LIMIT_CYCLES = 400000;
  localparam logic [3:0]  RESET_TERMS  = 4'd5;
  localparam logic [31:0] ANG_ONE      = 32'h1000_0000;   // 1.0 rad in Q3.28
  localparam logic [31:0] ANG_HALF_PI  = 32'd421657428;
  localparam logic [31:0] ANG_PI       = 32'd843314857;
  localparam logic [31:0] ANG_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] ANG_MIN      = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] sine;
    logic        last;
  } sine_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;     // [31:0] angle
  logic        in_tlast   = 1'b0;   // final_angle
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] sine_value
  logic        out_tlast;           // final_result
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;     // [3:0] num_terms

  sine_word_t  sine_expected_q[$];
  sine_word_t  sine_want;
  logic [3:0]  num_terms_set = RESET_TERMS;
  bit          idle_in  = 1'b1;
  bit          idle_out = 1'b1;
  int          choke_req = 0;
  int          errors    = 0;
  int          cycle_cnt = 0;

  taylor_sine_evaluator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Series sine on |x| in fixed point, sign of x applied at the end
  function automatic logic [31:0] series_sine(input logic [31:0] ang, input logic [3:0] terms);
    logic [31:0] ang_neg;
    logic [63:0] mag_x, x2, divisor, recip, fac, term, acc, mag_s, rnd;
    logic        neg_x, neg_s;
    int          n;
    neg_x   = ang[31];
    ang_neg = 32'd0 - ang;
    mag_x   = neg_x ? {32'd0, ang_neg} : {32'd0, ang};
    x2      = (mag_x * mag_x + 64'h8000_0000) >> 32;
    term    = mag_x << 2;
    acc     = term;
    n       = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
    for (int k = 1; k <= n; k++) begin
      divisor = 64'((2 * k) * (2 * k + 1));
      recip   = ((64'd1 << 32) + divisor / 2) / divisor;
      fac     = (x2 * recip + 64'h8000_0000) >> 32;
      term    = (term * fac + 64'h0080_0000) >> 24;
      acc     = (k % 2 == 1) ? acc - term : acc + term;
    end
    neg_s = acc[63];
    mag_s = neg_s ? 64'd0 - acc : acc;
    rnd   = (mag_s + 64'd32) >> 6;
    if (rnd == 64'd0)
      return 32'd0;
    if (neg_s != neg_x)
      return (rnd >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - rnd[31:0];
    return (rnd > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rnd[31:0];
  endfunction

  // Mix of full-range, in-circle, near-limit and tiny angles
  function automatic logic [31:0] pick_angle();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom();
      4, 5, 6:    v = 32'($urandom_range(0, 32'd1686629714)) - ANG_PI;
      7:          v = $urandom_range(0, 1) ? ANG_MAX - $urandom_range(0, 255)
                                           : ANG_MIN + $urandom_range(0, 255);
      default: begin
        v = $urandom_range(0, 65535);
        if ($urandom_range(0, 1))
          v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  // Offer one angle word, hold it until taken, record its expected sine
  task automatic send_angle(input logic [31:0] ang, input logic last);
    int gap;
    gap = idle_in ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ang;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sine_expected_q.push_back('{sine: series_sine(ang, num_terms_set), last: last});
  endtask

  // Stop offering and wait for the pipe to empty
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (sine_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_terms(input logic [3:0] n);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data  <= {4'd0, n};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    num_terms_set = n;
  endtask

  // Zero, one LSB, full-scale limits and a few landmark angles, reset term count
  task automatic test_directed_angles();
    send_angle(32'd0, 1'b0);
    send_angle(32'd1, 1'b1);
    send_angle(32'hFFFF_FFFF, 1'b0);
    send_angle(ANG_MAX, 1'b0);
    send_angle(ANG_MIN, 1'b1);
    send_angle(ANG_ONE, 1'b0);
    send_angle(32'd0 - ANG_ONE, 1'b0);
    send_angle(ANG_HALF_PI, 1'b1);
    send_angle(32'd0 - ANG_HALF_PI, 1'b0);
    send_angle(ANG_PI, 1'b0);
    send_angle(32'd0 - ANG_PI, 1'b1);
    send_angle(32'h5555_5555, 1'b0);
    send_angle(32'hAAAA_AAAA, 1'b1);
    send_angle(ANG_ONE >> 1, 1'b0);
    drain_pipe();
  endtask

  // Every term count, above the maximum too, on the extremes, half pi and a random angle
  task automatic test_term_sweep();
    for (int n = 0; n < 16; n++) begin
      write_terms(4'(n));
      send_angle(ANG_MAX, 1'b0);
      send_angle(ANG_MIN, 1'b0);
      send_angle(ANG_HALF_PI, 1'b0);
      send_angle(pick_angle(), 1'b1);
    end
  endtask

  // Random streams in phases, each with its own term count and idling
  task automatic test_random_stream();
    logic [3:0] n;
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       n = 4'd0;
        1:       n = 4'(MAX_TERMS);
        2:       n = 4'd15;
        3:       n = RESET_TERMS;
        default: n = 4'($urandom_range(0, 15));
      endcase
      write_terms(n);
      idle_in  = (ph != 0) && ($urandom_range(0, 3) != 0);
      idle_out = (ph != 0) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++)
        send_angle(pick_angle(), $urandom_range(0, 7) == 0);
    end
    drain_pipe();
    idle_in  = 1'b1;
    idle_out = 1'b1;
  endtask

  // Hold the receiver off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    write_terms(4'(MAX_TERMS));
    idle_in   = 1'b0;
    choke_req = CHOKE_CYCLES;
    for (int i = 0; i < 60; i++)
      send_angle(pick_angle(), i == 59);
    drain_pipe();
    idle_in = 1'b1;
  endtask

  // Receiver: random stall per word, or a long hold-off on request
  initial begin
    int stall;
    forever begin
      if (choke_req > 0) begin
        out_tready <= 1'b0;
        repeat (choke_req) @(posedge clk);
        choke_req = 0;
      end else begin
        stall = idle_out ? $urandom_range(0, MAX_GAP) : 0;
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (sine_expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual sine %h last %b",
                 $time, out_tdata, out_tlast);
      end else begin
        sine_want = sine_expected_q.pop_front();
        if (out_tdata !== sine_want.sine) begin
          errors++;
          $display("%0t: sine mismatch, expected %h, actual %h",
                   $time, sine_want.sine, out_tdata);
        end
        if (out_tlast !== sine_want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %b, actual %b",
                   $time, sine_want.last, out_tlast);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_angles();
    test_term_sweep();
    test_random_stream();
    test_backpressure();
    drain_pipe();
    if (errors == 0 && sine_expected_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[files.f]
hw/rtl/tse_pkg.sv
hw/rtl/tse_term.sv
hw/rtl/taylor_sine_evaluator_core.sv
dv/tb.sv
